// ----- sv/ipv4dq_pkg.sv -----
// Package for the IPv4 dotted-quad parser: character codes, limits and
// result codes. No dependencies.
`default_nettype none

package ipv4dq_pkg;

  // Character codes and limits.
  localparam logic [7:0] PERIOD_CODE = 8'd46;
  localparam logic [7:0] DIGIT_LOW   = 8'd48;
  localparam logic [7:0] DIGIT_HIGH  = 8'd57;
  localparam logic [9:0] OCTET_LIMIT = 10'd256;
  localparam logic [2:0] OCTET_COUNT = 3'd4;
  localparam logic [2:0] TOKEN_MAX   = 3'd3;
  localparam logic [2:0] TOKEN_SAT   = 3'd4;

  // Result codes.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_TOKEN = 2'd1,
    ERR_TOO_FEW   = 2'd2,
    ERR_TOO_MANY  = 2'd3
  } err_kind_t;

endpackage

`default_nettype wire

// ----- sv/ipv4_dotted_quad_parser_top.sv -----
// Top level of the IPv4 dotted-quad parser: input word register, token and
// address state, and the result register. Uses ipv4dq_pkg.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid, in_stall | char_code, final_char
//   out     | output    | out_valid,out_stall| address_ok, address_value, error_kind
//
// A word is taken into the input register and parsed while held there, so a
// new word is accepted every cycle while the input is not stalled.
// A result is loaded into the output register when its final word is parsed.
// The input stalls only while a final word waits behind a result that is
// itself stalled; ordinary characters pass a stalled result freely.
// Reset (rst, synchronous) clears all valids and the parse state.
`default_nettype none

module ipv4_dotted_quad_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        final_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             address_ok,
  output logic [31:0]      address_value,
  output logic [1:0]       error_kind
);

  // Input word register.
  logic       in_reg_valid;
  logic [7:0] in_reg_char;
  logic       in_reg_final;

  // Parse state.
  logic [9:0]  token_value;
  logic [2:0]  token_length;
  logic        token_has_nondigit;
  logic [2:0]  octets_accepted;
  logic [1:0]  failure_kind;
  logic [31:0] address_accum;

  // Next values.
  logic [9:0]  token_value_next;
  logic [2:0]  token_length_next;
  logic        token_has_nondigit_next;
  logic [2:0]  octets_accepted_next;
  logic [1:0]  failure_kind_next;
  logic [31:0] address_accum_next;

  logic        advance;
  logic        out_free;
  logic        is_period;
  logic        is_digit;
  logic [9:0]  upd_value;
  logic [2:0]  upd_length;
  logic        upd_nondigit;
  logic [9:0]  cls_value;
  logic [2:0]  cls_length;
  logic        cls_nondigit;
  logic        do_close;
  logic [2:0]  oct_after;
  logic [1:0]  fail_after;
  logic [31:0] accum_after;
  logic [1:0]  kind_final;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  // A held word leaves unless it is final and the result slot is blocked.
  assign advance  = in_reg_valid && (!in_reg_final || out_free);
  assign in_stall = in_reg_valid && !advance;

  // Input word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg_char  <= char_code;
      in_reg_final <= final_char;
    end
  end

  // Character class.
  assign is_period = (in_reg_char == ipv4dq_pkg::PERIOD_CODE);
  assign is_digit  = (in_reg_char >= ipv4dq_pkg::DIGIT_LOW) &&
                     (in_reg_char <= ipv4dq_pkg::DIGIT_HIGH);

  // Token after taking in a non-period character. The value only grows
  // through the first three characters, so it stays below 1000.
  always_comb begin
    upd_value    = token_value;
    upd_nondigit = token_has_nondigit;
    upd_length   = token_length;
    if (is_digit) begin
      if (token_length < ipv4dq_pkg::TOKEN_MAX) begin
        upd_value = {token_value[6:0], 3'b000} + {token_value[8:0], 1'b0} +
                    {6'd0, in_reg_char[3:0]};
      end
    end else begin
      upd_nondigit = 1'b1;
    end
    if (token_length < ipv4dq_pkg::TOKEN_SAT) begin
      upd_length = token_length + 3'd1;
    end
  end

  // Close the token: a period closes the token as it stands; a final
  // non-period closes the token that includes it.
  assign cls_value    = is_period ? token_value : upd_value;
  assign cls_length   = is_period ? token_length : upd_length;
  assign cls_nondigit = is_period ? token_has_nondigit : upd_nondigit;
  assign do_close     = is_period || in_reg_final;

  always_comb begin
    oct_after   = octets_accepted;
    fail_after  = failure_kind;
    accum_after = address_accum;
    if (do_close && (cls_length != 3'd0) &&
        (failure_kind == ipv4dq_pkg::ERR_NONE)) begin
      if (octets_accepted >= ipv4dq_pkg::OCTET_COUNT) begin
        fail_after = ipv4dq_pkg::ERR_TOO_MANY;
      end else if ((cls_length <= ipv4dq_pkg::TOKEN_MAX) && !cls_nondigit &&
                   (cls_value < ipv4dq_pkg::OCTET_LIMIT)) begin
        accum_after = {address_accum[23:0], cls_value[7:0]};
        oct_after   = octets_accepted + 3'd1;
      end else begin
        fail_after = ipv4dq_pkg::ERR_BAD_TOKEN;
      end
    end
  end

  // Kind reported at the end of the text.
  always_comb begin
    kind_final = fail_after;
    if ((fail_after == ipv4dq_pkg::ERR_NONE) &&
        (oct_after != ipv4dq_pkg::OCTET_COUNT)) begin
      kind_final = ipv4dq_pkg::ERR_TOO_FEW;
    end
  end

  // Next parse state: a final word returns everything to reset.
  always_comb begin
    token_value_next        = token_value;
    token_length_next       = token_length;
    token_has_nondigit_next = token_has_nondigit;
    octets_accepted_next    = octets_accepted;
    failure_kind_next       = failure_kind;
    address_accum_next      = address_accum;
    if (advance) begin
      if (in_reg_final) begin
        token_value_next        = 10'd0;
        token_length_next       = 3'd0;
        token_has_nondigit_next = 1'b0;
        octets_accepted_next    = 3'd0;
        failure_kind_next       = ipv4dq_pkg::ERR_NONE;
        address_accum_next      = 32'd0;
      end else if (is_period) begin
        token_value_next        = 10'd0;
        token_length_next       = 3'd0;
        token_has_nondigit_next = 1'b0;
        octets_accepted_next    = oct_after;
        failure_kind_next       = fail_after;
        address_accum_next      = accum_after;
      end else begin
        token_value_next        = upd_value;
        token_length_next       = upd_length;
        token_has_nondigit_next = upd_nondigit;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_value        <= 10'd0;
      token_length       <= 3'd0;
      token_has_nondigit <= 1'b0;
      octets_accepted    <= 3'd0;
      failure_kind       <= ipv4dq_pkg::ERR_NONE;
      address_accum      <= 32'd0;
    end else begin
      token_value        <= token_value_next;
      token_length       <= token_length_next;
      token_has_nondigit <= token_has_nondigit_next;
      octets_accepted    <= octets_accepted_next;
      failure_kind       <= failure_kind_next;
      address_accum      <= address_accum_next;
    end
  end

  // Result register: loaded by a final word, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && in_reg_final;
    end
    if (out_free && advance && in_reg_final) begin
      address_ok    <= (kind_final == ipv4dq_pkg::ERR_NONE);
      address_value <= (kind_final == ipv4dq_pkg::ERR_NONE) ? accum_after : 32'd0;
      error_kind    <= kind_final;
    end
  end

endmodule

`default_nettype wire
